FILE: hw/rtl/u2d_pkg.sv
package u2d_pkg;

  localparam int MagWidth   = 64;
  localparam int ScaleWidth = 12;
  localparam int ExpWidth   = 13;
  localparam int MantWidth  = 53;
  localparam int FracBits   = 52;
  localparam int LzcWidth   = 6;

  localparam logic signed [ExpWidth-1:0] ExpOffset = 13'sd1086;
  localparam logic signed [ExpWidth-1:0] ExpMax    = 13'sd2047;
  localparam logic [MagWidth-1:0]        InfBits   = 64'h7ff0_0000_0000_0000;

  typedef struct packed {
    logic [MagWidth-1:0]          mag;
    logic signed [ScaleWidth-1:0] scale;
    logic [LzcWidth-1:0]          lzc;
    logic                         nonzero;
  } lead_t;

  typedef struct packed {
    logic [MantWidth-1:0]       mant;
    logic                       sticky;
    logic signed [ExpWidth-1:0] biased;
    logic                       nonzero;
  } norm_t;

  typedef struct packed {
    logic [MagWidth-1:0] bits;
    logic                inf;
    logic                flush;
  } result_t;

  function automatic logic [LzcWidth-1:0] lead_zeros(input logic [MagWidth-1:0] value);
    logic [MagWidth-1:0] v;
    logic [LzcWidth-1:0] lz;
    v  = value;
    lz = '0;
    if (v[63:32] == 32'd0) begin
      lz[5] = 1'b1;
      v     = {v[31:0], 32'd0};
    end
    if (v[63:48] == 16'd0) begin
      lz[4] = 1'b1;
      v     = {v[47:0], 16'd0};
    end
    if (v[63:56] == 8'd0) begin
      lz[3] = 1'b1;
      v     = {v[55:0], 8'd0};
    end
    if (v[63:60] == 4'd0) begin
      lz[2] = 1'b1;
      v     = {v[59:0], 4'd0};
    end
    if (v[63:62] == 2'd0) begin
      lz[1] = 1'b1;
      v     = {v[61:0], 2'd0};
    end
    if (v[63] == 1'b0) begin
      lz[0] = 1'b1;
    end
    return lz;
  endfunction

endpackage

FILE: hw/rtl/uint64_to_double_scaled.sv
// Converts an unsigned 64-bit integer times a signed power of two into a
// binary64 pattern (sign always zero). Wide values are rounded towards plus
// infinity; results below the normal range flush to +0 and those above give
// +infinity, each reported on tuser. Three register stages (leading-zero
// count, normalising shift, round and pack): one item per cycle; a stall at
// the output holds all stages.
module uint64_to_double_scaled (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // magnitude[63:0], scale_exponent[75:64], zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // double_bits[63:0]
  output logic [1:0]  m_axis_tuser   // went_infinite[0], flushed_zero[1]
);

  logic             en;
  logic             lead_valid;
  logic             norm_valid;
  logic             pack_valid;
  u2d_pkg::lead_t   lead_data;
  u2d_pkg::norm_t   norm_data;
  u2d_pkg::result_t pack_data;

  assign en            = !pack_valid || m_axis_tready;
  assign s_axis_tready = en;

  u2d_lead u_lead (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .in_valid       (s_axis_tvalid),
    .magnitude      (s_axis_tdata[63:0]),
    .scale_exponent ($signed(s_axis_tdata[75:64])),
    .out_valid      (lead_valid),
    .out_data       (lead_data)
  );

  u2d_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (lead_valid),
    .in_data   (lead_data),
    .out_valid (norm_valid),
    .out_data  (norm_data)
  );

  u2d_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (norm_valid),
    .in_data   (norm_data),
    .out_valid (pack_valid),
    .out_data  (pack_data)
  );

  assign m_axis_tvalid = pack_valid;
  assign m_axis_tdata  = pack_data.bits;
  assign m_axis_tuser  = {pack_data.flush, pack_data.inf};

endmodule

FILE: hw/rtl/u2d_lead.sv
module u2d_lead (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic [u2d_pkg::MagWidth-1:0]           magnitude,
  input  logic signed [u2d_pkg::ScaleWidth-1:0]  scale_exponent,
  output logic                                   out_valid,
  output u2d_pkg::lead_t                         out_data
);

  logic           valid;
  u2d_pkg::lead_t data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data.mag     <= magnitude;
      data.scale   <= scale_exponent;
      data.lzc     <= u2d_pkg::lead_zeros(magnitude);
      data.nonzero <= (magnitude != '0);
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

FILE: hw/rtl/u2d_norm.sv
module u2d_norm (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  u2d_pkg::lead_t in_data,
  output logic           out_valid,
  output u2d_pkg::norm_t out_data
);

  logic [u2d_pkg::MagWidth-1:0]              shifted;
  logic signed [u2d_pkg::ExpWidth-1:0]       biased_next;
  logic                                      valid;
  u2d_pkg::norm_t                            data;

  // leading one lands on bit 63; low bits beyond the mantissa fold into sticky
  assign shifted     = in_data.mag << in_data.lzc;
  assign biased_next = {in_data.scale[u2d_pkg::ScaleWidth-1], in_data.scale}
                       + u2d_pkg::ExpOffset
                       - $signed({{(u2d_pkg::ExpWidth-u2d_pkg::LzcWidth){1'b0}}, in_data.lzc});

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data.mant    <= shifted[63:11];
      data.sticky  <= |shifted[10:0];
      data.biased  <= biased_next;
      data.nonzero <= in_data.nonzero;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

FILE: hw/rtl/u2d_pack.sv
module u2d_pack (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  u2d_pkg::norm_t   in_data,
  output logic             out_valid,
  output u2d_pkg::result_t out_data
);

  logic [u2d_pkg::MantWidth:0]         rounded;
  logic signed [u2d_pkg::ExpWidth-1:0] biased;
  logic                                valid;
  u2d_pkg::result_t                    data;
  u2d_pkg::result_t                    data_next;

  assign rounded = {1'b0, in_data.mant}
                   + {{u2d_pkg::MantWidth{1'b0}}, in_data.sticky};
  assign biased  = in_data.biased
                   + $signed({{(u2d_pkg::ExpWidth-1){1'b0}}, rounded[u2d_pkg::MantWidth]});

  always_comb begin
    data_next = '0;
    if (in_data.nonzero) begin
      if (biased <= 0) begin
        data_next.flush = 1'b1;
      end else if (biased >= u2d_pkg::ExpMax) begin
        data_next.bits = u2d_pkg::InfBits;
        data_next.inf  = 1'b1;
      end else begin
        data_next.bits = {1'b0, biased[10:0], rounded[u2d_pkg::FracBits-1:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule
